// ===== hdl/bmgd_pkg.sv =====
// shared types and codes for the button multipress gesture decoder
package bmgd_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int WINDOW_BITS       = 16;
   localparam int CSR_INDEX_BITS    = 2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MULTI_PRESS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COMBO       = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHAIN       = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLDOFF     = 2'd3;

   // register reset values
   localparam logic [WINDOW_BITS-1:0] MULTI_PRESS_RESET = 16'd300;
   localparam logic [WINDOW_BITS-1:0] COMBO_RESET       = 16'd80;
   localparam logic [WINDOW_BITS-1:0] CHAIN_RESET       = 16'd800;
   localparam logic [WINDOW_BITS-1:0] HOLDOFF_RESET     = 16'd500;

   // request opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_LEFT  = 2'd1;
   localparam logic [1:0] OP_RIGHT = 2'd2;
   localparam logic [1:0] OP_POWER = 2'd3;

   // playback status codes
   localparam logic [1:0] ST_PLAYING = 2'd1;
   localparam logic [1:0] ST_PAUSED  = 2'd2;

   // action codes
   localparam logic [3:0] ACT_TOGGLE_MODE = 4'd0;
   localparam logic [3:0] ACT_DIR_UP      = 4'd1;
   localparam logic [3:0] ACT_SHUFFLE     = 4'd2;
   localparam logic [3:0] ACT_RESTART     = 4'd3;
   localparam logic [3:0] ACT_PREVIOUS    = 4'd4;
   localparam logic [3:0] ACT_ENTER       = 4'd5;
   localparam logic [3:0] ACT_LOOP        = 4'd6;
   localparam logic [3:0] ACT_NEXT        = 4'd7;
   localparam logic [3:0] ACT_PAUSE       = 4'd8;
   localparam logic [3:0] ACT_RESUME      = 4'd9;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_ms;
      logic [1:0]  playback_status;
   } req_type;

   typedef struct packed {
      logic [3:0] action;
      logic       mode_is_player;
      logic       shuffle_enabled;
      logic       loop_enabled;
      logic       last_of_run;
   } rsp_type;

   // results produced by one request, in order
   typedef struct packed {
      logic [1:0] push_count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

// ===== hdl/bmgd_decode.sv =====
// gesture state, configuration registers and per-request decode logic
module bmgd_decode import bmgd_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  req_type                   item,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WINDOW_BITS-1:0]    csr_data,
   output push_type                  push
);

   logic [WINDOW_BITS-1:0] multi_press_ff, combo_ff, chain_ff, holdoff_ff;

   logic                 mode_ff, mode_in;
   logic                 shuffle_ff, shuffle_in;
   logic                 loop_ff, loop_in;
   logic [1:0]           count_ff [0:1];
   logic [1:0]           count_in [0:1];
   logic [TIME_BITS-1:0] deadline_ff [0:1];
   logic [TIME_BITS-1:0] deadline_in [0:1];
   logic [TIME_BITS-1:0] press_ff [0:1];
   logic [TIME_BITS-1:0] press_in [0:1];
   logic [TIME_BITS-1:0] restart_ff, restart_in;
   logic [TIME_BITS-1:0] power_ff, power_in;

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] left_due_diff, right_due_diff, chain_diff, combo_diff, power_diff;
   logic                 side, other;
   logic                 l_due, r_due, combo_hit, power_ok;

   logic [3:0]           act_l, act_r;
   logic                 shuffle_l, loop_r;
   logic [TIME_BITS-1:0] restart_l;
   rsp_type              res_l, res_r;

   assign now_t = TIME_BITS'(item.now_ms);
   assign side  = (item.opcode == OP_RIGHT);
   assign other = ~side;

   // wrapping differences
   assign left_due_diff  = now_t - deadline_ff[0];
   assign right_due_diff = now_t - deadline_ff[1];
   assign chain_diff     = now_t - restart_ff;
   assign combo_diff     = now_t - press_ff[other];
   assign power_diff     = now_t - power_ff;

   assign l_due     = (count_ff[0] != 2'd0) && !left_due_diff[TIME_BITS-1];
   assign r_due     = (count_ff[1] != 2'd0) && !right_due_diff[TIME_BITS-1];
   assign combo_hit = combo_diff <= TIME_BITS'(combo_ff);
   assign power_ok  = power_diff >= TIME_BITS'(holdoff_ff);

   always_comb begin
      mode_in     = mode_ff;
      shuffle_in  = shuffle_ff;
      loop_in     = loop_ff;
      count_in    = count_ff;
      deadline_in = deadline_ff;
      press_in    = press_ff;
      restart_in  = restart_ff;
      power_in    = power_ff;
      push        = '0;

      // left dispatch
      shuffle_l = shuffle_ff;
      restart_l = restart_ff;
      act_l     = ACT_PREVIOUS;
      case (count_ff[0])
         2'd1: begin
            restart_l = '0;
            if (mode_ff) begin
               shuffle_l = ~shuffle_ff;
               act_l     = ACT_SHUFFLE;
            end else begin
               act_l = ACT_DIR_UP;
            end
         end
         2'd2: begin
            if ((restart_ff != '0) && (chain_diff <= TIME_BITS'(chain_ff))) begin
               restart_l = '0;
               act_l     = ACT_PREVIOUS;
            end else begin
               restart_l = now_t;
               act_l     = ACT_RESTART;
            end
         end
         default: begin
            restart_l = '0;
            act_l     = ACT_PREVIOUS;
         end
      endcase

      // right dispatch
      loop_r = loop_ff;
      if (count_ff[1] == 2'd1) begin
         if (mode_ff) begin
            loop_r = ~loop_ff;
            act_r  = ACT_LOOP;
         end else begin
            act_r = ACT_ENTER;
         end
      end else begin
         act_r = ACT_NEXT;
      end

      // left result sees the old loop flag, right result sees the new shuffle flag
      res_l = '{action: act_l, mode_is_player: mode_ff, shuffle_enabled: shuffle_l,
                loop_enabled: loop_ff, last_of_run: ~r_due};
      res_r = '{action: act_r, mode_is_player: mode_ff,
                shuffle_enabled: l_due ? shuffle_l : shuffle_ff,
                loop_enabled: loop_r, last_of_run: 1'b1};

      if (fire) begin
         case (item.opcode)
            OP_TICK: begin
               if (l_due) begin
                  count_in[0] = 2'd0;
                  shuffle_in  = shuffle_l;
                  restart_in  = restart_l;
               end
               if (r_due) begin
                  count_in[1] = 2'd0;
                  loop_in     = loop_r;
               end
               if (l_due && r_due) begin
                  push.push_count = 2'd2;
                  push.first      = res_l;
                  push.second     = res_r;
               end else if (l_due) begin
                  push.push_count = 2'd1;
                  push.first      = res_l;
               end else if (r_due) begin
                  push.push_count = 2'd1;
                  push.first      = res_r;
               end
            end
            OP_LEFT, OP_RIGHT: begin
               if (combo_hit) begin
                  count_in[0]     = 2'd0;
                  count_in[1]     = 2'd0;
                  press_in[0]     = '0;
                  press_in[1]     = '0;
                  mode_in         = ~mode_ff;
                  push.push_count = 2'd1;
                  push.first      = '{action: ACT_TOGGLE_MODE, mode_is_player: ~mode_ff,
                                      shuffle_enabled: shuffle_ff, loop_enabled: loop_ff,
                                      last_of_run: 1'b1};
               end else begin
                  deadline_in[side] = now_t + TIME_BITS'(multi_press_ff);
                  if (count_ff[side] != 2'd3) begin
                     count_in[side] = count_ff[side] + 2'd1;
                  end
                  press_in[side] = now_t;
               end
            end
            default: begin
               if (power_ok) begin
                  power_in = now_t;
                  if (item.playback_status == ST_PLAYING) begin
                     push.push_count = 2'd1;
                     push.first      = '{action: ACT_PAUSE, mode_is_player: mode_ff,
                                         shuffle_enabled: shuffle_ff, loop_enabled: loop_ff,
                                         last_of_run: 1'b1};
                  end else if (item.playback_status == ST_PAUSED) begin
                     push.push_count = 2'd1;
                     push.first      = '{action: ACT_RESUME, mode_is_player: mode_ff,
                                         shuffle_enabled: shuffle_ff, loop_enabled: loop_ff,
                                         last_of_run: 1'b1};
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         multi_press_ff <= MULTI_PRESS_RESET;
         combo_ff       <= COMBO_RESET;
         chain_ff       <= CHAIN_RESET;
         holdoff_ff     <= HOLDOFF_RESET;
         mode_ff        <= 1'b0;
         shuffle_ff     <= 1'b0;
         loop_ff        <= 1'b0;
         count_ff[0]    <= 2'd0;
         count_ff[1]    <= 2'd0;
         deadline_ff[0] <= '0;
         deadline_ff[1] <= '0;
         press_ff[0]    <= '0;
         press_ff[1]    <= '0;
         restart_ff     <= '0;
         power_ff       <= '0;
      end else begin
         mode_ff     <= mode_in;
         shuffle_ff  <= shuffle_in;
         loop_ff     <= loop_in;
         count_ff    <= count_in;
         deadline_ff <= deadline_in;
         press_ff    <= press_in;
         restart_ff  <= restart_in;
         power_ff    <= power_in;
         if (csr_write) begin
            case (csr_index)
               CSR_MULTI_PRESS: multi_press_ff <= csr_data;
               CSR_COMBO:       combo_ff       <= csr_data;
               CSR_CHAIN:       chain_ff       <= csr_data;
               CSR_HOLDOFF:     holdoff_ff     <= csr_data;
               default:         ;
            endcase
         end
      end
   end

endmodule

// ===== hdl/bmgd_rsp_queue.sv =====
// small queue that takes up to two results a cycle and, unstalled, hands out one
module bmgd_rsp_queue import bmgd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   rsp_type             entries_ff [0:QUEUE_DEPTH-1];
   logic [PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entries_ff[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // space for the two results a tick can give
   assign room      = count_ff <= CNT_BITS'(QUEUE_DEPTH - 2);

   assign wr_in    = wr_ff + PTR_BITS'(push.push_count);
   assign rd_in    = rd_ff + PTR_BITS'(pop);
   assign count_in = count_ff + CNT_BITS'(push.push_count) - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (push.push_count != 2'd0) begin
         entries_ff[wr_ff] <= push.first;
      end
      if (push.push_count == 2'd2) begin
         entries_ff[wr_ff + PTR_BITS'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/button_multipress_gesture_decoder.sv =====
// top level of the button multipress gesture decoder
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  req_data  (opcode, now_ms, playback_status)
//   rsp_     out        rsp_valid / rsp_stall  rsp_data  (action, flags, last_of_run)
//   csr_     in         csr_valid / csr_ready  csr_index, csr_data
//
// a request is decoded in one pass from the input register; its results enter a four-entry
// queue, which drives rsp_ directly; a new request can be taken every cycle while
// req_stall is low; a tick gives up to two results, paid out one per cycle while rsp_stall
// is low, and req_stall rises only while a request is held and the queue lacks room for two
// synchronous reset clears flags, counts, timestamps and the queue and loads the default
// windows; csr_ready is always high
module button_multipress_gesture_decoder import bmgd_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WINDOW_BITS-1:0]    csr_data
);

   // input register
   logic     valid_ff, valid_in;
   req_type  item_ff;
   logic     accept, advance, room;
   push_type push;

   assign advance   = valid_ff && room;
   assign req_stall = valid_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !advance);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // decode one request against the gesture state
   bmgd_decode #(
      .TIME_BITS(TIME_BITS)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (item_ff),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push      (push)
   );

   // result register and skid space toward the consumer
   bmgd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/tb_button_multipress_gesture_decoder.sv =====
// self-checking testbench for the button multipress gesture decoder
module tb_button_multipress_gesture_decoder;
   import bmgd_pkg::*;

   // playback status codes the package leaves unnamed
   localparam logic [1:0] ST_STOPPED = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd3;

   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 40;
   localparam int ITEMS_PER_PHASE = 180;
   localparam int PHASES          = 8;

   // how a directed row is checked: gesture predictor, no result, or a typed result
   typedef enum logic [1:0] {
      CHECK_PREDICTED,
      CHECK_NONE,
      CHECK_ONE
   } check_kind_type;

   typedef struct packed {
      check_kind_type kind;
      req_type        req;
      rsp_type        fixed;
   } directed_row_type;

   // clock, reset and block ports; every input starts at a known value
   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [WINDOW_BITS-1:0]    csr_data  = '0;

   // predictor copy of the windows, starting at their reset values
   logic [WINDOW_BITS-1:0] multi_win   = MULTI_PRESS_RESET;
   logic [WINDOW_BITS-1:0] combo_win   = COMBO_RESET;
   logic [WINDOW_BITS-1:0] chain_win   = CHAIN_RESET;
   logic [WINDOW_BITS-1:0] holdoff_win = HOLDOFF_RESET;

   // predictor copy of the gesture state; index 0 is left, 1 is right
   logic        player_mode = 1'b0;
   logic        shuffle_on  = 1'b0;
   logic        loop_on     = 1'b0;
   logic [1:0]  press_count    [2] = '{2'd0, 2'd0};
   logic [31:0] press_deadline [2] = '{32'd0, 32'd0};
   logic [31:0] side_press_at  [2] = '{32'd0, 32'd0};
   logic [31:0] restart_at = '0;
   logic [31:0] power_at   = '0;

   // actions produced by the latest request, and actions still owed by the block
   rsp_type          fresh [2];
   int               fresh_n;
   rsp_type          expected_actions [$];
   directed_row_type directed_rows [$];

   int          mismatch_count = 0;
   int          items_sent     = 0;
   int          send_idle_pct  = 0;
   int          stall_pct      = 0;
   logic [31:0] cursor;

   always #4 clock = ~clock;

   button_multipress_gesture_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // one action with the flags as they stand after it
   function automatic void emit_action(input logic [3:0] act);
      fresh[fresh_n] = rsp_type'{act, player_mode, shuffle_on, loop_on, 1'b0};
      fresh_n++;
   endfunction

   // advance the predicted state by one request and collect its actions
   task automatic decode_gesture(input req_type r);
      logic [31:0] now;
      logic [31:0] gap;
      logic [3:0]  act;
      int          b;
      now     = r.now_ms;
      fresh_n = 0;
      case (r.opcode)
         OP_TICK: begin
            // left first, then right; a deadline is reached when now - deadline is
            // not negative in wrapping arithmetic
            for (b = 0; b < 2; b++) begin
               gap = now - press_deadline[b];
               if (press_count[b] != 2'd0 && !gap[31]) begin
                  if (b == 0) begin
                     if (press_count[0] == 2'd1) begin
                        restart_at = '0;
                        if (player_mode) begin
                           shuffle_on = ~shuffle_on;
                           act        = ACT_SHUFFLE;
                        end else begin
                           act = ACT_DIR_UP;
                        end
                     end else if (press_count[0] == 2'd2) begin
                        // second double press soon after a restart means previous
                        gap = now - restart_at;
                        if (restart_at != '0 && gap <= chain_win) begin
                           restart_at = '0;
                           act        = ACT_PREVIOUS;
                        end else begin
                           restart_at = now;
                           act        = ACT_RESTART;
                        end
                     end else begin
                        restart_at = '0;
                        act        = ACT_PREVIOUS;
                     end
                  end else if (press_count[1] == 2'd1) begin
                     if (player_mode) begin
                        loop_on = ~loop_on;
                        act     = ACT_LOOP;
                     end else begin
                        act = ACT_ENTER;
                     end
                  end else begin
                     act = ACT_NEXT;
                  end
                  press_count[b] = 2'd0;
                  emit_action(act);
               end
            end
         end
         OP_LEFT, OP_RIGHT: begin
            b   = (r.opcode == OP_LEFT) ? 0 : 1;
            gap = now - side_press_at[1 - b];
            if (gap <= combo_win) begin
               // both side buttons close together: cancel counts, flip the mode
               press_count[0]   = 2'd0;
               press_count[1]   = 2'd0;
               side_press_at[0] = '0;
               side_press_at[1] = '0;
               player_mode      = ~player_mode;
               emit_action(ACT_TOGGLE_MODE);
            end else begin
               press_deadline[b] = now + multi_win;
               if (press_count[b] != 2'd3) begin
                  press_count[b]++;
               end
               side_press_at[b] = now;
            end
         end
         default: begin
            // power press; accepted outside the hold-off even when nothing plays
            gap = now - power_at;
            if (gap >= holdoff_win) begin
               power_at = now;
               if (r.playback_status == ST_PLAYING) begin
                  emit_action(ACT_PAUSE);
               end else if (r.playback_status == ST_PAUSED) begin
                  emit_action(ACT_RESUME);
               end
            end
         end
      endcase
      if (fresh_n > 0) begin
         fresh[fresh_n - 1].last_of_run = 1'b1;
      end
   endtask

   // offer one request, wait for it to be taken, then record what it owes
   task automatic send_req(input req_type r, input check_kind_type kind,
                           input rsp_type fixed);
      int i;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      decode_gesture(r);
      if (kind == CHECK_PREDICTED) begin
         for (i = 0; i < fresh_n; i++) begin
            expected_actions.push_back(fresh[i]);
         end
      end else if (kind == CHECK_ONE) begin
         expected_actions.push_back(fixed);
      end
   endtask

   task automatic send_at(input logic [1:0] op, input logic [31:0] now);
      req_type r;
      r.opcode          = op;
      r.now_ms          = now;
      r.playback_status = 2'($urandom_range(0, 3));
      send_req(r, CHECK_PREDICTED, '0);
      items_sent++;
   endtask

   task automatic add_row(input check_kind_type kind, input logic [1:0] op,
                          input logic [31:0] now, input logic [1:0] status,
                          input rsp_type fixed);
      directed_row_type row;
      row.kind                = kind;
      row.req.opcode          = op;
      row.req.now_ms          = now;
      row.req.playback_status = status;
      row.fixed               = fixed;
      directed_rows.push_back(row);
   endtask

   // all owed actions delivered, then a settling wait for requests that owe none
   task automatic wait_idle();
      while (expected_actions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four windows back to back; only called while the block is idle
   task automatic configure_windows(input logic [15:0] m, input logic [15:0] c,
                                    input logic [15:0] ch, input logic [15:0] h);
      logic [CSR_INDEX_BITS-1:0] idx;
      logic [WINDOW_BITS-1:0]    value;
      int                        k;
      for (k = 0; k < 4; k++) begin
         idx = CSR_INDEX_BITS'(k);
         case (idx)
            CSR_MULTI_PRESS: begin value = m;  multi_win   = m;  end
            CSR_COMBO:       begin value = c;  combo_win   = c;  end
            CSR_CHAIN:       begin value = ch; chain_win   = ch; end
            default:         begin value = h;  holdoff_win = h;  end
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= value;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // one well-formed gesture with random content, or a stray request
   task automatic play_gesture();
      logic [1:0] side_op;
      logic [1:0] other_op;
      int         kind;
      int         n;
      int         i;
      kind     = $urandom_range(0, 99);
      side_op  = ($urandom_range(0, 1) == 0) ? OP_LEFT : OP_RIGHT;
      other_op = (side_op == OP_LEFT) ? OP_RIGHT : OP_LEFT;
      cursor   += $urandom_range(1, 3000);
      if (kind < 30) begin
         // burst of presses on one side, sometimes joined by the other side
         // outside the combo window, then a tick around the deadline
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) begin
            if (i > 0) begin
               cursor += $urandom_range(0, multi_win);
            end
            send_at(side_op, cursor);
         end
         if ($urandom_range(0, 3) == 0) begin
            cursor += combo_win + 1 + $urandom_range(0, 20);
            send_at(other_op, cursor);
         end
         // one ms early, on time or one ms late
         cursor += multi_win + $urandom_range(0, 2) - 1;
         send_at(OP_TICK, cursor);
         if ($urandom_range(0, 1) == 0) begin
            cursor += $urandom_range(1, 2);
            send_at(OP_TICK, cursor);
         end
      end else if (kind < 45) begin
         // two double presses on the left: restart, then maybe previous
         repeat (2) begin
            send_at(OP_LEFT, cursor);
            cursor += $urandom_range(0, multi_win);
            send_at(OP_LEFT, cursor);
            cursor += multi_win;
            send_at(OP_TICK, cursor);
            cursor += $urandom_range(0, chain_win + 50);
         end
      end else if (kind < 60) begin
         // both sides near the combo window edge, then flush any counts
         send_at(side_op, cursor);
         cursor += $urandom_range(0, combo_win + 2);
         send_at(other_op, cursor);
         cursor += multi_win + 1;
         send_at(OP_TICK, cursor);
      end else if (kind < 75) begin
         // power press at the hold-off edge or anywhere up to twice it
         if ($urandom_range(0, 1) == 0) begin
            cursor += holdoff_win + $urandom_range(0, 2) - 1;
         end else begin
            cursor += $urandom_range(0, 2 * holdoff_win);
         end
         send_at(OP_POWER, cursor);
      end else if (kind < 90) begin
         cursor += $urandom_range(0, 2 * multi_win);
         send_at(OP_TICK, cursor);
      end else begin
         // noise: any opcode at any time, sometimes moving the timeline there
         n = $urandom;
         send_at(2'($urandom_range(0, 3)), n);
         if ($urandom_range(0, 1) == 0) begin
            cursor = n;
         end
      end
   endtask

   // result side: check each taken action, then stall at random for the next edge
   always @(posedge clock) begin : take_action
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_actions.size() == 0) begin
            report_mismatch($sformatf("unexpected action %0d", rsp_data.action));
         end else begin
            want = expected_actions.pop_front();
            if (rsp_data.action !== want.action) begin
               report_mismatch($sformatf("action %0d, expected %0d",
                                         rsp_data.action, want.action));
            end
            if (rsp_data.mode_is_player !== want.mode_is_player) begin
               report_mismatch($sformatf("mode_is_player %b, expected %b",
                                         rsp_data.mode_is_player, want.mode_is_player));
            end
            if (rsp_data.shuffle_enabled !== want.shuffle_enabled) begin
               report_mismatch($sformatf("shuffle_enabled %b, expected %b",
                                         rsp_data.shuffle_enabled, want.shuffle_enabled));
            end
            if (rsp_data.loop_enabled !== want.loop_enabled) begin
               report_mismatch($sformatf("loop_enabled %b, expected %b",
                                         rsp_data.loop_enabled, want.loop_enabled));
            end
            if (rsp_data.last_of_run !== want.last_of_run) begin
               report_mismatch($sformatf("last_of_run %b, expected %b",
                                         rsp_data.last_of_run, want.last_of_run));
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   initial begin
      directed_row_type row;
      int               phase;
      int               i;

      // directed table, default windows: multi 300, combo 80, chain 800, holdoff 500
      // nothing pending, so a tick at time zero does nothing
      add_row(CHECK_NONE, OP_TICK,  32'd0,    ST_STOPPED, '0);
      // power hold-off, pause and resume
      add_row(CHECK_ONE,  OP_POWER, 32'd1000, ST_PLAYING,
              rsp_type'{ACT_PAUSE, 1'b0, 1'b0, 1'b0, 1'b1});
      add_row(CHECK_NONE, OP_POWER, 32'd1200, ST_PAUSED,  '0);
      add_row(CHECK_ONE,  OP_POWER, 32'd1500, ST_PAUSED,
              rsp_type'{ACT_RESUME, 1'b0, 1'b0, 1'b0, 1'b1});
      // accepted power presses with nothing to pause or resume
      add_row(CHECK_NONE, OP_POWER, 32'd2100, ST_STOPPED, '0);
      add_row(CHECK_NONE, OP_POWER, 32'd2700, ST_UNKNOWN, '0);
      // single left press: one ms before the deadline, then on it
      add_row(CHECK_NONE, OP_LEFT,  32'd10000, ST_UNKNOWN, '0);
      add_row(CHECK_NONE, OP_TICK,  32'd10299, ST_STOPPED, '0);
      add_row(CHECK_ONE,  OP_TICK,  32'd10300, ST_STOPPED,
              rsp_type'{ACT_DIR_UP, 1'b0, 1'b0, 1'b0, 1'b1});
      // combo exactly at the window edge switches to player mode
      add_row(CHECK_NONE, OP_RIGHT, 32'd20000, ST_PLAYING, '0);
      add_row(CHECK_ONE,  OP_LEFT,  32'd20080, ST_PAUSED,
              rsp_type'{ACT_TOGGLE_MODE, 1'b1, 1'b0, 1'b0, 1'b1});
      // one ms past the combo window: both sides count, one tick gives two actions
      add_row(CHECK_NONE,      OP_LEFT,  32'd30000, ST_STOPPED, '0);
      add_row(CHECK_NONE,      OP_RIGHT, 32'd30081, ST_STOPPED, '0);
      add_row(CHECK_PREDICTED, OP_TICK,  32'd30400, ST_STOPPED, '0);
      // restart, then a double press inside the chain window gives previous
      add_row(CHECK_NONE,      OP_LEFT,  32'd40000, ST_STOPPED, '0);
      add_row(CHECK_NONE,      OP_LEFT,  32'd40100, ST_STOPPED, '0);
      add_row(CHECK_ONE,       OP_TICK,  32'd40400, ST_STOPPED,
              rsp_type'{ACT_RESTART, 1'b1, 1'b1, 1'b1, 1'b1});
      add_row(CHECK_NONE,      OP_LEFT,  32'd40600, ST_STOPPED, '0);
      add_row(CHECK_NONE,      OP_LEFT,  32'd40700, ST_STOPPED, '0);
      add_row(CHECK_PREDICTED, OP_TICK,  32'd41000, ST_STOPPED, '0);
      // right double press gives next
      add_row(CHECK_NONE,      OP_RIGHT, 32'd50000, ST_STOPPED, '0);
      add_row(CHECK_NONE,      OP_RIGHT, 32'd50001, ST_STOPPED, '0);
      add_row(CHECK_PREDICTED, OP_TICK,  32'd50303, ST_STOPPED, '0);
      // deadline wraps to zero, restart stored at time zero counts as none,
      // so the next double press is a restart again
      add_row(CHECK_NONE,      OP_LEFT,  32'hFFFF_FED4, ST_STOPPED, '0);
      add_row(CHECK_NONE,      OP_LEFT,  32'hFFFF_FED4, ST_STOPPED, '0);
      add_row(CHECK_PREDICTED, OP_TICK,  32'h0000_0000, ST_STOPPED, '0);
      add_row(CHECK_NONE,      OP_LEFT,  32'd100,       ST_STOPPED, '0);
      add_row(CHECK_NONE,      OP_LEFT,  32'd110,       ST_STOPPED, '0);
      add_row(CHECK_PREDICTED, OP_TICK,  32'd410,       ST_STOPPED, '0);

      // synchronous reset, applied once
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed walk with no idling on either side
      for (i = 0; i < directed_rows.size(); i++) begin
         row = directed_rows[i];
         send_req(row.req, row.kind, row.fixed);
      end
      req_valid <= 1'b0;
      wait_idle();

      // random phases: each one reprograms the windows while idle and cycles
      // through the idling patterns
      cursor = $urandom;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 58; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 58; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         case (phase)
            0: configure_windows(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)),
                                 16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)));
            1: configure_windows(16'h0000, 16'h0000, 16'h0000, 16'h0000);
            2: configure_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: configure_windows(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
            4: configure_windows(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
            default: configure_windows(16'($urandom_range(0, 2000)),
                                       16'($urandom_range(0, 200)),
                                       16'($urandom_range(0, 3000)),
                                       16'($urandom_range(0, 1500)));
         endcase
         items_sent = 0;
         while (items_sent < ITEMS_PER_PHASE) begin
            play_gesture();
         end
         req_valid <= 1'b0;
         wait_idle();
      end

      // room for any stray action to show up
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/bmgd_pkg.sv
hdl/bmgd_decode.sv
hdl/bmgd_rsp_queue.sv
hdl/button_multipress_gesture_decoder.sv
test/tb_button_multipress_gesture_decoder.sv
